@@ design/snsi_pkg.sv @@
`timescale 1ns / 1ps
package snsi_pkg;

  localparam int SEQ_W          = 16;
  localparam int STATUS_W       = 2;
  localparam int FILL_W         = 7;
  localparam int LIST_DEPTH_DEF = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // compare results of one cell against the incoming value
  typedef struct packed {
    logic eq;
    logic ent_prec;  // held entry comes before the value
    logic val_prec;  // value comes before the held entry
  } cell_flags_t;

  // serial-number order: x before y when y - x lies in 1..32767
  function automatic logic seq_precedes(input logic [SEQ_W-1:0] x,
                                        input logic [SEQ_W-1:0] y);
    logic [SEQ_W-1:0] d;
    d = y - x;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

@@ design/snsi_cell.sv @@
`timescale 1ns / 1ps
module snsi_cell (
  input  logic                          clk,
  input  logic                          cap,
  input  logic                          upd,
  input  logic [snsi_pkg::SEQ_W-1:0]    val,
  input  logic                          valid,
  input  logic [snsi_pkg::SEQ_W-1:0]    left_entry,
  input  logic                          s_left,
  input  logic                          p_in,
  input  logic                          d_in,
  input  snsi_pkg::cell_flags_t         nxt_flags,
  input  logic                          nxt_valid,
  input  logic                          any_pair,
  input  logic                          front,
  output logic [snsi_pkg::SEQ_W-1:0]    entry,
  output snsi_pkg::cell_flags_t         flags,
  output logic                          s_out,
  output logic                          p_out,
  output logic                          d_out
);

  logic [snsi_pkg::SEQ_W-1:0] entry_r;
  snsi_pkg::cell_flags_t      flags_r;
  snsi_pkg::cell_flags_t      flags_nxt;
  logic                       pair;

  always_comb begin
    flags_nxt.eq       = (entry_r == val);
    flags_nxt.ent_prec = snsi_pkg::seq_precedes(entry_r, val);
    flags_nxt.val_prec = snsi_pkg::seq_precedes(val, entry_r);
  end

  // value fits between this entry and the next one
  assign pair  = valid && flags_r.ent_prec && nxt_valid && nxt_flags.val_prec;
  assign p_out = p_in | pair;
  assign d_out = d_in | (valid & flags_r.eq);

  // this cell sits at or above the insert position
  always_comb begin
    if (any_pair) begin
      s_out = p_in;
    end else if (front) begin
      s_out = 1'b1;
    end else begin
      s_out = !valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      flags_r <= flags_nxt;
    end
    if (upd && s_out) begin
      entry_r <= s_left ? left_entry : val;
    end
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule

@@ design/serial_number_sorted_insert_core.sv @@
`timescale 1ns / 1ps
// Sorted list of 16-bit sequence numbers in serial-number (wraparound) order.
// Input: drive in_seq_number and raise start while busy is low; the beat is
// taken at that edge and busy stays high through the compare and update states.
// Each beat yields exactly one result: out_valid is high for one cycle with
// out_status (inserted, duplicate rejected, list full and dropped) and
// out_fill_count, the number of entries held afterwards.
// Timing: compare in S_CMP, shift/insert in S_UPD, the result shows in the
// cycle after that; a new beat is taken only once the last one is through,
// set by the compare stage followed by the ripple of the position chain across
// the cells before the shift.
// Each cell holds one entry, compares it with the new value and takes its
// left neighbor's entry when the list opens up for an insert.
// Reset clears the fill count and the control state; entries are simply
// overwritten as the list grows, so no clearing pass is needed.
// The receiver cannot stall: each result is there for one cycle only.
module serial_number_sorted_insert_core #(
  parameter int LIST_DEPTH = snsi_pkg::LIST_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [snsi_pkg::SEQ_W-1:0]      in_seq_number,
  output logic                            out_valid,
  output logic [snsi_pkg::STATUS_W-1:0]   out_status,
  output logic [snsi_pkg::FILL_W-1:0]     out_fill_count
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t                           state_r;
  logic [CW-1:0]                    count_r;
  logic [snsi_pkg::SEQ_W-1:0]       val_r;
  logic                             out_valid_r;
  snsi_pkg::status_t                out_status_r;
  logic [snsi_pkg::FILL_W-1:0]      out_fill_r;

  logic [snsi_pkg::SEQ_W-1:0]       entry_w [LIST_DEPTH];
  snsi_pkg::cell_flags_t            flags_w [LIST_DEPTH+1];
  logic [LIST_DEPTH:0]              valid_w;
  logic [LIST_DEPTH:0]              s_w;
  logic [LIST_DEPTH:0]              p_w;
  logic [LIST_DEPTH:0]              d_w;

  logic                             front;
  logic                             dup;
  logic                             full;
  logic                             ins;
  logic                             upd;
  logic [CW-1:0]                    count_nxt;

  assign s_w[0]              = 1'b0;
  assign p_w[0]              = 1'b0;
  assign d_w[0]              = 1'b0;
  assign valid_w[LIST_DEPTH] = 1'b0;
  assign flags_w[LIST_DEPTH] = '0;

  assign front = valid_w[0] && flags_w[0].val_prec;
  assign dup   = d_w[LIST_DEPTH];
  assign full  = (count_r == CW'(LIST_DEPTH));
  assign ins   = !dup && !full;
  assign upd   = (state_r == S_UPD) && ins;
  assign count_nxt = ins ? count_r + CW'(1) : count_r;

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic [snsi_pkg::SEQ_W-1:0] left_entry;

      assign valid_w[gi] = (count_r > CW'(gi));

      if (gi == 0) begin : g_first
        assign left_entry = val_r;
      end else begin : g_rest
        assign left_entry = entry_w[gi-1];
      end

      snsi_cell u_cell (
        .clk        (clk),
        .cap        (state_r == S_CMP),
        .upd        (upd),
        .val        (val_r),
        .valid      (valid_w[gi]),
        .left_entry (left_entry),
        .s_left     (s_w[gi]),
        .p_in       (p_w[gi]),
        .d_in       (d_w[gi]),
        .nxt_flags  (flags_w[gi+1]),
        .nxt_valid  (valid_w[gi+1]),
        .any_pair   (p_w[LIST_DEPTH]),
        .front      (front),
        .entry      (entry_w[gi]),
        .flags      (flags_w[gi]),
        .s_out      (s_w[gi+1]),
        .p_out      (p_w[gi+1]),
        .d_out      (d_w[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            val_r   <= in_seq_number;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
          out_fill_r  <= snsi_pkg::FILL_W'(count_nxt);
          if (dup) begin
            out_status_r <= snsi_pkg::ST_DUPLICATE;
          end else if (full) begin
            out_status_r <= snsi_pkg::ST_FULL;
          end else begin
            out_status_r <= snsi_pkg::ST_INSERTED;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int SEQ_W    = snsi_pkg::SEQ_W;
  localparam int STATUS_W = snsi_pkg::STATUS_W;
  localparam int FILL_W   = snsi_pkg::FILL_W;
  localparam int DEPTH    = snsi_pkg::LIST_DEPTH_DEF;
  localparam int N_DIR    = 18;
  localparam int N_RANDOM = 1732;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [SEQ_W-1:0]    in_seq_number = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FILL_W-1:0]   out_fill_count;

  typedef struct packed {
    snsi_pkg::status_t status;
    logic [FILL_W-1:0] fill;
  } verdict_t;

  typedef struct {
    logic [SEQ_W-1:0]  seq;
    bit                typed;  // expected result written into the row
    snsi_pkg::status_t st;
    logic [FILL_W-1:0] fill;
  } dir_row_t;

  // shadow copy of the list, kept in serial-number order
  logic [SEQ_W-1:0] held_seq [DEPTH];
  int               held_count = 0;
  logic [SEQ_W-1:0] drift_base;

  verdict_t pending_verdicts [$];
  dir_row_t dir_rows [N_DIR];

  int err_count = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_ins     = 0;
  int n_dup     = 0;
  int n_full    = 0;

  serial_number_sorted_insert_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seq_number  (in_seq_number),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: timeout with %0d results outstanding", pending_verdicts.size());
    $display("tb: done, errors");
    $finish;
  end

  // x comes first when y - x lies in 1..32767
  function automatic bit comes_first(input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] y);
    logic [SEQ_W-1:0] gap;
    gap = y - x;
    return (gap != 16'd0) && (gap < 16'h8000);
  endfunction

  function automatic verdict_t insert_in_order(input logic [SEQ_W-1:0] v);
    verdict_t r;
    bit       dup;
    bit       found;
    int       pos;
    int       i;
    dup   = 1'b0;
    found = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (held_seq[i] == v) dup = 1'b1;
    end
    if (dup) begin
      r.status = snsi_pkg::ST_DUPLICATE;
    end else if (held_count >= DEPTH) begin
      r.status = snsi_pkg::ST_FULL;
    end else begin
      r.status = snsi_pkg::ST_INSERTED;
      pos = held_count;
      // first gap that fits wins
      for (i = 0; i + 1 < held_count && !found; i++) begin
        if (comes_first(held_seq[i], v) && comes_first(v, held_seq[i+1])) begin
          pos   = i + 1;
          found = 1'b1;
        end
      end
      if (!found && held_count > 0 && comes_first(v, held_seq[0])) pos = 0;
      for (i = held_count; i > pos; i--) held_seq[i] = held_seq[i-1];
      held_seq[pos] = v;
      held_count++;
    end
    r.fill = FILL_W'(held_count);
    return r;
  endfunction

  function automatic logic [SEQ_W-1:0] next_random_seq();
    int               r;
    int               dup_pct;
    logic [SEQ_W-1:0] pick;
    r       = $urandom_range(99);
    dup_pct = (held_count >= DEPTH) ? 50 : 15;
    if (held_count > 0 && r < dup_pct) begin
      return held_seq[$urandom_range(held_count - 1)];
    end
    if (r < dup_pct + 15) return SEQ_W'($urandom);
    if (held_count > 0 && r < dup_pct + 25) begin
      // right at or next to half a circle away from a held entry
      pick = held_seq[$urandom_range(held_count - 1)] ^ 16'h8000;
      return pick + SEQ_W'($urandom_range(2)) - 16'd1;
    end
    drift_base = drift_base + SEQ_W'($urandom_range(48));
    return drift_base + SEQ_W'($urandom_range(255)) - 16'd128;
  endfunction

  task automatic send_beat(input logic [SEQ_W-1:0] v, input bit typed, input verdict_t want);
    verdict_t got;
    start         <= 1'b1;
    in_seq_number <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = insert_in_order(v);
    case (got.status)
      snsi_pkg::ST_INSERTED:  n_ins++;
      snsi_pkg::ST_DUPLICATE: n_dup++;
      default:                n_full++;
    endcase
    pending_verdicts.push_back(typed ? want : got);
    n_sent++;
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_verdicts.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("tb: unexpected result status=%0d fill=%0d at %0t",
                   out_status, out_fill_count, $realtime);
      end else begin
        want = pending_verdicts.pop_front();
        n_checked++;
        if (out_status !== want.status || out_fill_count !== want.fill) begin
          err_count++;
          if (err_count <= 10)
            $display("tb: result %0d mismatch: status exp %0d got %0d, fill exp %0d got %0d",
                     n_checked, want.status, out_status, want.fill, out_fill_count);
        end
      end
    end
  end

  initial begin
    verdict_t         want;
    logic [SEQ_W-1:0] v;
    int               k;
    int               phase;
    int               idle_pct;

    dir_rows[0]  = '{16'h0000, 1'b1, snsi_pkg::ST_INSERTED,  7'd1};
    dir_rows[1]  = '{16'h0000, 1'b1, snsi_pkg::ST_DUPLICATE, 7'd1};
    // older than everything held: goes to the front
    dir_rows[2]  = '{16'hFFFF, 1'b1, snsi_pkg::ST_INSERTED,  7'd2};
    // half a circle from 0 but before 0xFFFF: goes to the front
    dir_rows[3]  = '{16'h8000, 1'b1, snsi_pkg::ST_INSERTED,  7'd3};
    dir_rows[4]  = '{16'h0001, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[5]  = '{16'hFFFF, 1'b1, snsi_pkg::ST_DUPLICATE, 7'd4};
    dir_rows[6]  = '{16'h7FFF, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[7]  = '{16'h8001, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[8]  = '{16'h4000, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[9]  = '{16'hC000, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[10] = '{16'h8000, 1'b1, snsi_pkg::ST_DUPLICATE, 7'd8};
    dir_rows[11] = '{16'h0002, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[12] = '{16'hFFFE, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[13] = '{16'h5555, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[14] = '{16'hAAAA, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[15] = '{16'h0100, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[16] = '{16'h00FF, 1'b0, snsi_pkg::ST_INSERTED,  7'd0};
    dir_rows[17] = '{16'h0001, 1'b1, snsi_pkg::ST_DUPLICATE, 7'd14};

    drift_base = 16'hFF00 - SEQ_W'($urandom_range(1023));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIR; k++) begin
      want.status = dir_rows[k].st;
      want.fill   = dir_rows[k].fill;
      send_beat(dir_rows[k].seq, dir_rows[k].typed, want);
      idle_gap(13);
    end
    // hold the sender off until the block has answered every beat
    wait_drained();

    want = '0;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 13 : (phase == 1) ? 49 : 0;
      for (k = 0; k < N_RANDOM / 3; k++) begin
        v = next_random_seq();
        send_beat(v, 1'b0, want);
        idle_gap(idle_pct);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      err_count += pending_verdicts.size();
      $display("tb: %0d results never arrived", pending_verdicts.size());
    end

    $display("tb: %0d beats sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, err_count);
    $display("tb: %0d inserted, %0d duplicates, %0d dropped on a full list",
             n_ins, n_dup, n_full);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
